FILE: src/bprm_pkg.sv
// Shared constants for the block peak and RMS level meter.
package bprm_pkg;

    localparam int SAMPLE_BITS             = 16;
    localparam int PEAK_W                  = SAMPLE_BITS;
    localparam int SQ_W                    = 2 * SAMPLE_BITS - 1;
    localparam int ROOT_W                  = SAMPLE_BITS;
    localparam int COUNT_OUT_W             = 13;
    localparam int DEFAULT_MAX_BLOCK_ITEMS = 4096;
    localparam int QUEUE_DEPTH             = 2;

endpackage

FILE: src/bprm_in_if.sv
// Sample channel carrying one audio sample and its end-of-block flag.
interface bprm_in_if import bprm_pkg::*; ();

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_of_block;

    modport source (output valid, output sample, output last_of_block, input ready);
    modport sink   (input valid, input sample, input last_of_block, output ready);

endinterface

FILE: src/bprm_out_if.sv
// Result channel carrying the peak, RMS, sample count and overflow flag of a block.
interface bprm_out_if import bprm_pkg::*; ();

    logic                   valid;
    logic                   ready;
    logic [PEAK_W-1:0]      peak_level;
    logic [ROOT_W-1:0]      rms_level;
    logic [COUNT_OUT_W-1:0] samples_counted;
    logic                   overflow;

    modport source (output valid, output peak_level, output rms_level,
                    output samples_counted, output overflow, input ready);
    modport sink   (input valid, input peak_level, input rms_level,
                    input samples_counted, input overflow, output ready);

endinterface

FILE: src/bprm_front.sv
// Front end: takes samples, forms magnitudes and squares, and accumulates each block.
module bprm_front import bprm_pkg::*; #(
    parameter int MAX_BLOCK_ITEMS = DEFAULT_MAX_BLOCK_ITEMS,
    parameter int DATA_W          = PEAK_W + $clog2(MAX_BLOCK_ITEMS + 1) + SQ_W
                                    + $clog2(MAX_BLOCK_ITEMS + 1) + 1
) (
    input  logic              clk,
    input  logic              rst_n,
    bprm_in_if.sink           in_ch,
    output logic              push,
    output logic [DATA_W-1:0] push_data,
    input  logic              q_full
);

    localparam int CNT_W = $clog2(MAX_BLOCK_ITEMS + 1);
    localparam int SUM_W = CNT_W + SQ_W;

    logic                   s1_valid_reg;
    logic                   s1_last_reg;
    logic [PEAK_W-1:0]      s1_mag_reg;
    logic                   s2_valid_reg;
    logic                   s2_last_reg;
    logic [PEAK_W-1:0]      s2_mag_reg;
    logic [SQ_W-1:0]        s2_sq_reg;
    logic [PEAK_W-1:0]      peak_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   ovf_reg;

    logic                   stall;
    logic                   take;
    logic                   room;
    logic [PEAK_W-1:0]      raw;
    logic [PEAK_W-1:0]      mag;
    logic [2*PEAK_W-1:0]    product;
    logic [PEAK_W-1:0]      peak_next;
    logic [SUM_W-1:0]       sum_next;
    logic [CNT_W-1:0]       count_next;
    logic                   ovf_next;

    // A block end waiting at the accumulator holds the whole pipeline while the queue is full.
    assign stall       = s2_valid_reg && s2_last_reg && q_full;
    assign in_ch.ready = !stall;
    assign take        = s2_valid_reg && !stall;

    assign raw     = in_ch.sample[SAMPLE_BITS-1:0];
    assign mag     = raw[PEAK_W-1] ? (~raw + PEAK_W'(1)) : raw;
    assign product = s1_mag_reg * s1_mag_reg;

    assign room       = count_reg < CNT_W'(MAX_BLOCK_ITEMS);
    assign peak_next  = (room && (s2_mag_reg > peak_reg)) ? s2_mag_reg : peak_reg;
    assign sum_next   = room ? (sum_reg + SUM_W'(s2_sq_reg)) : sum_reg;
    assign count_next = room ? (count_reg + CNT_W'(1)) : count_reg;
    assign ovf_next   = ovf_reg || !room;

    assign push      = take && s2_last_reg;
    assign push_data = {peak_next, sum_next, count_next, ovf_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s2_last_reg  <= 1'b0;
            peak_reg     <= '0;
            sum_reg      <= '0;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
        end
        else if (!stall)
        begin
            s1_valid_reg <= in_ch.valid;
            s1_last_reg  <= in_ch.last_of_block;
            s2_valid_reg <= s1_valid_reg;
            s2_last_reg  <= s1_last_reg;
            if (take)
            begin
                if (s2_last_reg)
                begin
                    peak_reg  <= '0;
                    sum_reg   <= '0;
                    count_reg <= '0;
                    ovf_reg   <= 1'b0;
                end
                else
                begin
                    peak_reg  <= peak_next;
                    sum_reg   <= sum_next;
                    count_reg <= count_next;
                    ovf_reg   <= ovf_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            s1_mag_reg <= mag;
            s2_mag_reg <= s1_mag_reg;
            s2_sq_reg  <= product[SQ_W-1:0];
        end
    end

endmodule

FILE: src/bprm_queue.sv
// Short queue of block summaries between the front end and the back end.
module bprm_queue import bprm_pkg::*; #(
    parameter int DATA_W = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [OCC_W-1:0]  occ_reg;
    logic              do_push;
    logic              do_pop;

    assign full     = occ_reg == OCC_W'(QUEUE_DEPTH);
    assign empty    = occ_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            occ_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                occ_reg <= occ_reg + OCC_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                occ_reg <= occ_reg - OCC_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: src/bprm_back.sv
// Back end: divides the square sum by the count, takes the square root and emits the result.
module bprm_back import bprm_pkg::*; #(
    parameter int MAX_BLOCK_ITEMS = DEFAULT_MAX_BLOCK_ITEMS,
    parameter int DATA_W          = PEAK_W + $clog2(MAX_BLOCK_ITEMS + 1) + SQ_W
                                    + $clog2(MAX_BLOCK_ITEMS + 1) + 1
) (
    input  logic              clk,
    input  logic              rst_n,
    output logic              pop,
    input  logic [DATA_W-1:0] pop_data,
    input  logic              q_empty,
    bprm_out_if.source        out_ch
);

    localparam int CNT_W  = $clog2(MAX_BLOCK_ITEMS + 1);
    localparam int SUM_W  = CNT_W + SQ_W;
    localparam int STEP_W = $clog2(SUM_W + 1);
    localparam int RAD_W  = 2 * ROOT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_ROOT,
        ST_EMIT
    } state_t;

    state_t                   state_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [PEAK_W-1:0]        peak_reg;
    logic [CNT_W-1:0]         count_reg;
    logic                     ovf_reg;
    logic [SUM_W-1:0]         quot_reg;
    logic [CNT_W-1:0]         rem_reg;
    logic [RAD_W-1:0]         rad_reg;
    logic [ROOT_W:0]          rrem_reg;
    logic [ROOT_W-1:0]        root_reg;
    logic                     out_valid_reg;
    logic [PEAK_W-1:0]        out_peak_reg;
    logic [ROOT_W-1:0]        out_rms_reg;
    logic [COUNT_OUT_W-1:0]   out_count_reg;
    logic                     out_ovf_reg;

    logic [PEAK_W-1:0]        in_peak;
    logic [SUM_W-1:0]         in_sum;
    logic [CNT_W-1:0]         in_count;
    logic                     in_ovf;
    logic [CNT_W:0]           rem_shift;
    logic                     div_ge;
    logic [CNT_W:0]           rem_sub;
    logic [ROOT_W+2:0]        rrem_shift;
    logic [ROOT_W+2:0]        trial;
    logic                     root_ge;
    logic [ROOT_W+2:0]        rrem_sub;
    logic [CNT_W+COUNT_OUT_W-1:0] count_ext;
    logic                     out_free;

    assign {in_peak, in_sum, in_count, in_ovf} = pop_data;
    assign pop = (state_reg == ST_IDLE) && !q_empty;

    assign rem_shift = {rem_reg, quot_reg[SUM_W-1]};
    assign div_ge    = rem_shift >= {1'b0, count_reg};
    assign rem_sub   = rem_shift - {1'b0, count_reg};

    assign rrem_shift = {rrem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial      = {1'b0, root_reg, 2'b01};
    assign root_ge    = rrem_shift >= trial;
    assign rrem_sub   = rrem_shift - trial;

    assign count_ext = {{COUNT_OUT_W{1'b0}}, count_reg};
    assign out_free  = !out_valid_reg || out_ch.ready;

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.peak_level      = out_peak_reg;
    assign out_ch.rms_level       = out_rms_reg;
    assign out_ch.samples_counted = out_count_reg;
    assign out_ch.overflow        = out_ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        state_reg <= ST_DIVIDE;
                        step_reg  <= STEP_W'(SUM_W - 1);
                    end
                end
                ST_DIVIDE:
                begin
                    if (step_reg == '0)
                    begin
                        state_reg <= ST_ROOT;
                        step_reg  <= STEP_W'(ROOT_W - 1);
                    end
                    else
                    begin
                        step_reg <= step_reg - STEP_W'(1);
                    end
                end
                ST_ROOT:
                begin
                    if (step_reg == '0)
                    begin
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        step_reg <= step_reg - STEP_W'(1);
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                peak_reg  <= in_peak;
                count_reg <= in_count;
                ovf_reg   <= in_ovf;
                quot_reg  <= in_sum;
                rem_reg   <= '0;
            end
            ST_DIVIDE:
            begin
                quot_reg <= {quot_reg[SUM_W-2:0], div_ge};
                rem_reg  <= div_ge ? rem_sub[CNT_W-1:0] : rem_shift[CNT_W-1:0];
                if (step_reg == '0)
                begin
                    // A zero count cannot follow a counted sample, but it still yields zero.
                    rad_reg  <= (count_reg == '0) ? '0
                                                  : {quot_reg[RAD_W-2:0], div_ge};
                    rrem_reg <= '0;
                    root_reg <= '0;
                end
            end
            ST_ROOT:
            begin
                rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
                rrem_reg <= root_ge ? rrem_sub[ROOT_W:0] : rrem_shift[ROOT_W:0];
                root_reg <= {root_reg[ROOT_W-2:0], root_ge};
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_peak_reg  <= peak_reg;
                    out_rms_reg   <= root_reg;
                    out_count_reg <= count_ext[COUNT_OUT_W-1:0];
                    out_ovf_reg   <= ovf_reg;
                end
            end
            default:
            begin
                rem_reg <= '0;
            end
        endcase
    end

endmodule

FILE: src/block_peak_rms_meter.sv
// Block peak and RMS level meter top level.
// Samples are taken one per cycle while the front end is not stalled by a full queue;
// the front end accumulates behind its s1 and s2 pipeline registers. A result is
// emitted once the bit-serial divider and square root have run for its block.
// Up to two finished block summaries wait in the queue while the back end is busy.
// Reset clears the accumulators, the queue and all handshake state at once.
module block_peak_rms_meter import bprm_pkg::*; #(
    parameter int MAX_BLOCK_ITEMS = DEFAULT_MAX_BLOCK_ITEMS
) (
    input  logic       clk,
    input  logic       rst_n,
    bprm_in_if.sink    in_ch,
    bprm_out_if.source out_ch
);

    localparam int CNT_W  = $clog2(MAX_BLOCK_ITEMS + 1);
    localparam int DATA_W = PEAK_W + CNT_W + SQ_W + CNT_W + 1;

    logic              push;
    logic [DATA_W-1:0] push_data;
    logic              q_full;
    logic              pop;
    logic [DATA_W-1:0] pop_data;
    logic              q_empty;

    bprm_front #(
        .MAX_BLOCK_ITEMS (MAX_BLOCK_ITEMS),
        .DATA_W          (DATA_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    bprm_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    bprm_back #(
        .MAX_BLOCK_ITEMS (MAX_BLOCK_ITEMS),
        .DATA_W          (DATA_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop      (pop),
        .pop_data (pop_data),
        .q_empty  (q_empty),
        .out_ch   (out_ch)
    );

endmodule
